// ----- rtl/source_text_tokenizer_macros.svh -----
// Assertion macros for the source text tokenizer.
// Uses the clock and reset names of the module that includes it.
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define STT_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("source_text_tokenizer: same-cycle check failed");
`define STT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("source_text_tokenizer: next-cycle check failed");
`else
`define STT_ASSERT_SAME(label, ante, cons)
`define STT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- rtl/stt_pkg.sv -----
// Shared types, constants and the keyword table of the source text tokenizer.
// No dependencies.
package stt_pkg;

   localparam int POS_BITS       = 16;
   localparam int OUT_BITS       = 16;
   localparam int KW_MAX_LEN     = 9;
   localparam int KW_COUNT       = 10;
   localparam int KW_IDX_BITS    = $clog2(KW_MAX_LEN);
   localparam int KW_CNT_BITS    = $clog2(KW_MAX_LEN + 2);
   localparam int MAX_RESULTS    = 3;
   localparam int REQ_DATA_BITS  = 8;
   localparam int RSP_DATA_BITS  = 40;
   localparam int RSP_USER_BITS  = 5;

   localparam logic [3:0] NO_KEYWORD = 4'd10;

   typedef logic [POS_BITS-1:0] pos_type;
   typedef logic [7:0] word_buf_type [KW_MAX_LEN];

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_WORD,
      MODE_NUM,
      MODE_STR
   } mode_type;

   typedef enum logic [3:0] {
      KIND_KEYWORD   = 4'd0,
      KIND_IDENT     = 4'd1,
      KIND_ASSIGN    = 4'd2,
      KIND_STRING    = 4'd3,
      KIND_NUMBER    = 4'd4,
      KIND_SEMICOLON = 4'd5,
      KIND_DOT       = 4'd6,
      KIND_LPAREN    = 4'd7,
      KIND_RPAREN    = 4'd8,
      KIND_LBRACE    = 4'd9,
      KIND_RBRACE    = 4'd10,
      KIND_UNKNOWN   = 4'd11,
      KIND_END       = 4'd12
   } kind_type;

   typedef struct packed {
      logic                open_string;
      kind_type            kind;
      logic [3:0]          keyword_index;
      logic [OUT_BITS-1:0] start_position;
      logic [OUT_BITS-1:0] span_length;
      logic                last_result;
   } token_type;

   typedef struct packed {
      logic [1:0]                       count;
      token_type [MAX_RESULTS-1:0]      slot;
   } bundle_type;

   // Keyword text; each string literal is right-aligned, so the first character is in byte KW_LEN-1.
   localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
      "str", "int", "double", "float", "char",
      "in", {"array_", "str"}, {"array_", "int"}, "flow", "add"
   };
   localparam int KW_LEN [KW_COUNT] = '{3, 3, 6, 5, 4, 2, 9, 9, 4, 3};

   function automatic logic [7:0] kw_byte(input int k, input int i);
      logic [KW_MAX_LEN*8-1:0] shifted;
      shifted = '0;
      if (i < KW_LEN[k]) begin
         shifted = KW_TEXT[k] >> (8 * (KW_LEN[k] - 1 - i));
      end
      return shifted[7:0];
   endfunction

   function automatic logic [3:0] kw_lookup(input word_buf_type chars,
                                            input logic [KW_CNT_BITS-1:0] count);
      logic [3:0] idx;
      logic       hit;
      idx = NO_KEYWORD;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         hit = (count == KW_CNT_BITS'(KW_LEN[k]));
         for (int i = 0; i < KW_MAX_LEN; i++) begin
            if (i < KW_LEN[k] && chars[i] != kw_byte(k, i)) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            idx = 4'(k);
         end
      end
      return idx;
   endfunction

   function automatic logic [OUT_BITS-1:0] sat_out(input pos_type v);
      if ((v >> OUT_BITS) != '0) begin
         return '1;
      end
      return OUT_BITS'(v);
   endfunction

endpackage

// ----- rtl/stt_scanner.sv -----
// Scanner state and the per-byte token logic of the source text tokenizer.
// Depends on stt_pkg; produces a bundle of up to three tokens per byte.
module stt_scanner
   import stt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] char_byte,
   input  logic       final_byte,
   output bundle_type bundle
);

   mode_type                mode_ff, mode_in;
   pos_type                 start_ff, start_in;
   pos_type                 pos_ff, pos_in;
   logic [KW_CNT_BITS-1:0]  count_ff, count_in;
   word_buf_type            word_chars_ff, word_chars_in;

   function automatic logic is_alpha(input logic [7:0] c);
      return c inside {["A":"Z"], ["a":"z"]};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {["0":"9"]};
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'h20, [8'h09:8'h0D]};
   endfunction

   function automatic token_type make_token(input kind_type kind, input logic [3:0] kw,
                                            input pos_type start, input pos_type span,
                                            input logic open, input logic last);
      token_type t;
      t.kind           = kind;
      t.keyword_index  = kw;
      t.start_position = sat_out(start);
      t.span_length    = sat_out(span);
      t.open_string    = open;
      t.last_result    = last;
      return t;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         start_ff <= '0;
         pos_ff   <= '0;
         count_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         count_ff <= count_in;
      end
   end

   // The word buffer is only read below the fill count, so it needs no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         word_chars_ff <= word_chars_in;
      end
   end

   always_comb begin
      pos_type    np;
      logic       done;
      logic [1:0] n;
      logic [3:0] kw_old;
      logic [3:0] kw_new;
      kind_type   single;

      np     = (pos_ff != '1) ? pos_ff + 1'b1 : pos_ff;
      done   = 1'b0;
      n      = '0;
      kw_old = kw_lookup(word_chars_ff, count_ff);
      kw_new = NO_KEYWORD;
      single = KIND_UNKNOWN;
      bundle = '0;

      mode_in       = mode_ff;
      start_in      = start_ff;
      count_in      = count_ff;
      word_chars_in = word_chars_ff;

      // Continue or close the token in progress.
      case (mode_ff)
         MODE_WORD: begin
            if (is_alpha(char_byte) || is_digit(char_byte) || char_byte == "_") begin
               done = 1'b1;
               if (count_ff < KW_CNT_BITS'(KW_MAX_LEN)) begin
                  word_chars_in[count_ff[KW_IDX_BITS-1:0]] = char_byte;
               end
               if (count_ff <= KW_CNT_BITS'(KW_MAX_LEN)) begin
                  count_in = count_ff + 1'b1;
               end
            end else begin
               bundle.slot[n] = make_token((kw_old != NO_KEYWORD) ? KIND_KEYWORD : KIND_IDENT,
                                           kw_old, start_ff, pos_ff - start_ff, 1'b0, 1'b0);
               n = n + 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_NUM: begin
            if (is_digit(char_byte) || char_byte == ".") begin
               done = 1'b1;
            end else begin
               bundle.slot[n] = make_token(KIND_NUMBER, NO_KEYWORD, start_ff,
                                           pos_ff - start_ff, 1'b0, 1'b0);
               n = n + 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         MODE_STR: begin
            done = 1'b1;
            if (char_byte == "\"") begin
               bundle.slot[n] = make_token(KIND_STRING, NO_KEYWORD, start_ff,
                                           np - start_ff, 1'b0, 1'b0);
               n = n + 1'b1;
               mode_in = MODE_IDLE;
            end
         end
         default: begin
         end
      endcase

      // A byte not absorbed above starts a new token.
      if (!done && !is_space(char_byte)) begin
         if (is_alpha(char_byte) || char_byte == "_") begin
            mode_in          = MODE_WORD;
            start_in         = pos_ff;
            word_chars_in[0] = char_byte;
            count_in         = KW_CNT_BITS'(1);
         end else if (is_digit(char_byte)) begin
            mode_in  = MODE_NUM;
            start_in = pos_ff;
         end else if (char_byte == "\"") begin
            mode_in  = MODE_STR;
            start_in = pos_ff;
         end else begin
            case (char_byte)
               "=":     single = KIND_ASSIGN;
               ";":     single = KIND_SEMICOLON;
               ".":     single = KIND_DOT;
               "(":     single = KIND_LPAREN;
               ")":     single = KIND_RPAREN;
               "{":     single = KIND_LBRACE;
               "}":     single = KIND_RBRACE;
               default: single = KIND_UNKNOWN;
            endcase
            bundle.slot[n] = make_token(single, NO_KEYWORD, pos_ff, pos_type'(1), 1'b0, 1'b0);
            n = n + 1'b1;
         end
      end

      pos_in = np;

      // On the last byte, flush the open token, add the end marker and restart.
      if (final_byte) begin
         kw_new = kw_lookup(word_chars_in, count_in);
         case (mode_in)
            MODE_WORD: begin
               bundle.slot[n] = make_token((kw_new != NO_KEYWORD) ? KIND_KEYWORD : KIND_IDENT,
                                           kw_new, start_in, np - start_in, 1'b0, 1'b0);
               n = n + 1'b1;
            end
            MODE_NUM: begin
               bundle.slot[n] = make_token(KIND_NUMBER, NO_KEYWORD, start_in,
                                           np - start_in, 1'b0, 1'b0);
               n = n + 1'b1;
            end
            MODE_STR: begin
               bundle.slot[n] = make_token(KIND_STRING, NO_KEYWORD, start_in,
                                           np - start_in, 1'b1, 1'b0);
               n = n + 1'b1;
            end
            default: begin
            end
         endcase
         bundle.slot[n] = make_token(KIND_END, NO_KEYWORD, np, '0, 1'b0, 1'b1);
         n = n + 1'b1;
         mode_in  = MODE_IDLE;
         start_in = '0;
         pos_in   = '0;
         count_in = '0;
      end

      bundle.count = n;
   end

endmodule

// ----- rtl/stt_out_queue.sv -----
// Result register of the source text tokenizer: holds one byte's token bundle
// and hands its tokens out one per cycle while the result side is ready. Depends on stt_pkg.
module stt_out_queue
   import stt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  bundle_type bundle,
   output logic       load_ready,
   output logic       token_valid,
   output token_type  token,
   input  logic       token_ready
);

   logic                        valid_ff;
   logic [1:0]                  count_ff;
   logic [1:0]                  idx_ff;
   token_type [MAX_RESULTS-1:0] slot_ff;
   logic                        last_slot;

   assign last_slot   = (idx_ff == count_ff - 1'b1);
   assign load_ready  = !valid_ff || (token_ready && last_slot);
   assign token_valid = valid_ff;
   assign token       = slot_ff[idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
         count_ff <= '0;
      end else if (load) begin
         valid_ff <= (bundle.count != '0);
         idx_ff   <= '0;
         count_ff <= bundle.count;
      end else if (valid_ff && token_ready) begin
         if (last_slot) begin
            valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= bundle.slot;
      end
   end

endmodule

// ----- rtl/source_text_tokenizer.sv -----
// Source text tokenizer: one source byte per transaction in, tokens out.
// The first token of a byte shows on the result port, from the result register, in the cycle after the byte.
// Bytes are taken one per cycle while each causes at most one token and results are taken; a byte
// that causes two or three tokens holds the input until the result register hands out its last one.
// Reset (synchronous, active high) clears the scanner state and the result register.
`include "source_text_tokenizer_macros.svh"
module source_text_tokenizer
   import stt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,  // [7:0] char_byte
   input  logic                     req_tlast,  // final_byte
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,  // [3:0] keyword_index, [19:4] start_position,
                                                // [35:20] span_length, [39:36] zero
   output logic [RSP_USER_BITS-1:0] rsp_tuser,  // [3:0] token_kind, [4] open_string
   output logic                     rsp_tlast   // last_result
);

   logic       accept;
   bundle_type bundle;
   token_type  token;

   assign accept = req_tvalid && req_tready;

   stt_scanner u_scanner (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .char_byte  (req_tdata[7:0]),
      .final_byte (req_tlast),
      .bundle     (bundle)
   );

   stt_out_queue u_out_queue (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .bundle      (bundle),
      .load_ready  (req_tready),
      .token_valid (rsp_tvalid),
      .token       (token),
      .token_ready (rsp_tready)
   );

   assign rsp_tdata = {4'b0000, token.span_length, token.start_position, token.keyword_index};
   assign rsp_tuser = {token.open_string, token.kind};
   assign rsp_tlast = token.last_result;

   `STT_ASSERT_SAME(a_end_marker_shape, rsp_tvalid && rsp_tlast, rsp_tuser[3:0] == KIND_END && rsp_tdata[35:20] == '0)
   `STT_ASSERT_SAME(a_open_only_on_string, rsp_tvalid && rsp_tuser[4], rsp_tuser[3:0] == KIND_STRING)
   `STT_ASSERT_NEXT(a_final_gives_result, accept && req_tlast, rsp_tvalid)
   `STT_ASSERT_SAME(a_stall_only_when_busy, !req_tready, rsp_tvalid)

endmodule

// ----- sim/source_text_tokenizer_checker.sv -----
// Checker for the source text tokenizer: watches both stream channels, predicts the
// tokens of every accepted source byte and compares them with the result channel.
// Depends on stt_pkg for widths and token kinds.
module source_text_tokenizer_checker
   import stt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   input  logic                     req_tlast,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic [RSP_USER_BITS-1:0] rsp_tuser,
   input  logic                     rsp_tlast,
   output int                       fail_count,
   output int                       tokens_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned POS_LIMIT = (1 << POS_BITS) - 1;
   localparam int unsigned OUT_LIMIT = (1 << OUT_BITS) - 1;

   typedef struct {
      kind_type            kind;
      logic [3:0]          kw_index;
      logic [OUT_BITS-1:0] start;
      logic [OUT_BITS-1:0] span;
      logic                open_str;
      logic                last;
   } token_rec;

   string keyword_words [KW_COUNT] = '{
      "str", "int", "double", "float", "char",
      "in", {"array_", "str"}, {"array_", "int"}, "flow", "add"
   };

   token_rec    expected_tokens [$];
   int          errors = 0;

   // Scanner state of the predictor.
   mode_type    scan_state;
   logic [7:0]  word_buf [KW_MAX_LEN];
   int unsigned word_len;
   int unsigned tok_begin;
   int unsigned byte_pos;

   function automatic bit is_alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic bit is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "_";
   endfunction

   function automatic bit is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic int unsigned clip(input int unsigned v);
      return (v > OUT_LIMIT) ? OUT_LIMIT : v;
   endfunction

   function automatic kind_type punct_kind(input logic [7:0] c);
      case (c)
         "=":     return KIND_ASSIGN;
         ";":     return KIND_SEMICOLON;
         ".":     return KIND_DOT;
         "(":     return KIND_LPAREN;
         ")":     return KIND_RPAREN;
         "{":     return KIND_LBRACE;
         "}":     return KIND_RBRACE;
         default: return KIND_UNKNOWN;
      endcase
   endfunction

   function automatic logic [3:0] keyword_of();
      bit hit;
      for (int k = 0; k < KW_COUNT; k++) begin
         hit = (word_len == keyword_words[k].len());
         for (int i = 0; hit && i < keyword_words[k].len(); i++) begin
            if (word_buf[i] != keyword_words[k][i]) begin
               hit = 0;
            end
         end
         if (hit) begin
            return 4'(k);
         end
      end
      return NO_KEYWORD;
   endfunction

   task automatic clear_scanner();
      scan_state = MODE_IDLE;
      for (int i = 0; i < KW_MAX_LEN; i++) begin
         word_buf[i] = '0;
      end
      word_len  = 0;
      tok_begin = 0;
      byte_pos  = 0;
   endtask

   task automatic emit_token(input kind_type kind, input logic [3:0] kw,
                             input int unsigned start, input int unsigned span,
                             input logic open_str, input logic last);
      token_rec t;
      t.kind     = kind;
      t.kw_index = kw;
      t.start    = OUT_BITS'(clip(start));
      t.span     = OUT_BITS'(clip(span));
      t.open_str = open_str;
      t.last     = last;
      expected_tokens.insert(expected_tokens.size(), t);
   endtask

   task automatic emit_word(input int unsigned stop);
      logic [3:0] kw;
      kw = keyword_of();
      emit_token((kw == NO_KEYWORD) ? KIND_IDENT : KIND_KEYWORD, kw, tok_begin,
                 stop - tok_begin, 1'b0, 1'b0);
   endtask

   // The length counter stops one past the longest keyword, so an overlong word
   // never matches.
   task automatic append_word_char(input logic [7:0] c);
      if (word_len < KW_MAX_LEN) begin
         word_buf[word_len] = c;
      end
      if (word_len <= KW_MAX_LEN) begin
         word_len++;
      end
   endtask

   task automatic scan_byte(input logic [7:0] c, input logic fin);
      int unsigned p;
      int unsigned np;
      bit          consumed;
      p        = byte_pos;
      np       = (p < POS_LIMIT) ? p + 1 : p;
      consumed = 0;

      case (scan_state)
         MODE_WORD: begin
            if (is_word(c)) begin
               append_word_char(c);
               consumed = 1;
            end else begin
               emit_word(p);
               scan_state = MODE_IDLE;
            end
         end
         MODE_NUM: begin
            if (is_digit(c) || c == ".") begin
               consumed = 1;
            end else begin
               emit_token(KIND_NUMBER, NO_KEYWORD, tok_begin, p - tok_begin, 1'b0, 1'b0);
               scan_state = MODE_IDLE;
            end
         end
         MODE_STR: begin
            consumed = 1;
            if (c == "\"") begin
               emit_token(KIND_STRING, NO_KEYWORD, tok_begin, np - tok_begin, 1'b0, 1'b0);
               scan_state = MODE_IDLE;
            end
         end
         default: ;
      endcase

      // A byte not consumed above, including one that closed a word or number, starts over here.
      if (!consumed && !is_space(c)) begin
         if (is_alpha(c) || c == "_") begin
            scan_state = MODE_WORD;
            tok_begin  = p;
            word_len   = 0;
            append_word_char(c);
         end else if (is_digit(c)) begin
            scan_state = MODE_NUM;
            tok_begin  = p;
         end else if (c == "\"") begin
            scan_state = MODE_STR;
            tok_begin  = p;
         end else begin
            emit_token(punct_kind(c), NO_KEYWORD, p, 1, 1'b0, 1'b0);
         end
      end

      byte_pos = np;

      if (fin) begin
         case (scan_state)
            MODE_WORD: emit_word(np);
            MODE_NUM:  emit_token(KIND_NUMBER, NO_KEYWORD, tok_begin, np - tok_begin,
                                  1'b0, 1'b0);
            MODE_STR:  emit_token(KIND_STRING, NO_KEYWORD, tok_begin, np - tok_begin,
                                  1'b1, 1'b0);
            default: ;
         endcase
         emit_token(KIND_END, NO_KEYWORD, np, 0, 1'b0, 1'b1);
         clear_scanner();
      end
   endtask

   task automatic check_field(input string label, input int unsigned expv,
                              input int unsigned actv);
      if (expv != actv) begin
         $display("%0d ns: %s mismatch, expected %0d, actual %0d", $time, label, expv, actv);
         errors++;
      end
   endtask

   always @(posedge clock) begin : monitor
      token_rec head;
      if (reset) begin
         clear_scanner();
         expected_tokens.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            scan_byte(req_tdata[7:0], req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tokens.size() == 0) begin
               $display("%0d ns: token with none expected, kind %0d, start %0d", $time,
                        rsp_tuser[3:0], rsp_tdata[19:4]);
               errors++;
            end else begin
               head = expected_tokens.pop_front();
               check_field("token_kind", head.kind, rsp_tuser[3:0]);
               check_field("keyword_index", head.kw_index, rsp_tdata[3:0]);
               check_field("start_position", head.start, rsp_tdata[19:4]);
               check_field("span_length", head.span, rsp_tdata[35:20]);
               check_field("open_string", head.open_str, rsp_tuser[4]);
               check_field("last_result", head.last, rsp_tlast);
            end
         end
      end
      fail_count         <= errors;
      tokens_outstanding <= expected_tokens.size();
   end

endmodule

// ----- sim/testbench.sv -----
// Top of the source text tokenizer testbench: clock, reset, source byte stimulus,
// result channel back-pressure and the final verdict.
// Depends on stt_pkg, source_text_tokenizer and source_text_tokenizer_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import stt_pkg::*;

   localparam int RANDOM_BYTES  = 420;
   localparam int CHOKE_CYCLES  = 200;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata  = '0;
   logic                     req_tlast  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [RSP_USER_BITS-1:0] rsp_tuser;
   logic                     rsp_tlast;
   int                       fail_count;
   int                       tokens_outstanding;
   logic                     choke      = 1'b0;

   logic [7:0]               source_text [$];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   source_text_tokenizer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   source_text_tokenizer_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .req_tlast          (req_tlast),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .rsp_tuser          (rsp_tuser),
      .rsp_tlast          (rsp_tlast),
      .fail_count         (fail_count),
      .tokens_outstanding (tokens_outstanding)
   );

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] rand_word_char(input bit first);
      int r;
      r = $urandom_range(0, first ? 52 : 62);
      if (r < 26) begin
         return 8'("A" + r);
      end
      if (r < 52) begin
         return 8'("a" + r - 26);
      end
      if (r == 52) begin
         return "_";
      end
      return 8'("0" + r - 53);
   endfunction

   function automatic logic [7:0] rand_space();
      int r;
      r = $urandom_range(8, 13);
      return (r == 8) ? 8'(" ") : 8'(r);
   endfunction

   function automatic logic [7:0] rand_string_char();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == "\"");
      return b;
   endfunction

   task automatic add_byte(input logic [7:0] b);
      source_text.insert(source_text.size(), b);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         add_byte(s[i]);
      end
   endtask

   task automatic add_keyword(input int k, input int len);
      for (int i = 0; i < len; i++) begin
         add_byte(KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8]);
      end
   endtask

   task automatic add_string_body(input int len);
      repeat (len) add_byte(rand_string_char());
   endtask

   // One random source: mostly well-formed tokens with random separators,
   // sometimes plain noise.
   task automatic make_source();
      int    k;
      string puncts;
      puncts = "={}();.";
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(0, 255)));
         return;
      end
      repeat ($urandom_range(1, 12)) begin
         k = $urandom_range(0, KW_COUNT - 1);
         case ($urandom_range(0, 10))
            0, 1: begin
               add_keyword(k, KW_LEN[k]);
               if ($urandom_range(0, 3) == 0) begin
                  add_byte(rand_word_char(0));
               end
            end
            2: add_keyword(k, $urandom_range(1, KW_LEN[k]));
            3: begin
               add_byte(rand_word_char(1));
               repeat ($urandom_range(0, 13)) add_byte(rand_word_char(0));
            end
            4: begin
               add_byte(8'("0" + $urandom_range(0, 9)));
               repeat ($urandom_range(0, 6)) begin
                  add_byte(($urandom_range(0, 4) == 0) ? 8'(".") :
                           8'("0" + $urandom_range(0, 9)));
               end
            end
            5: begin
               add_byte("\"");
               add_string_body($urandom_range(0, 6));
               add_byte("\"");
            end
            6, 7: add_byte(puncts[$urandom_range(0, 6)]);
            8: add_byte(8'($urandom_range(0, 255)));
            default: repeat ($urandom_range(1, 3)) add_byte(rand_space());
         endcase
         if ($urandom_range(0, 2) != 0) begin
            repeat ($urandom_range(1, 2)) add_byte(rand_space());
         end
      end
      // Sometimes the source ends inside a string.
      if ($urandom_range(0, 5) == 0) begin
         add_byte("\"");
         add_string_body($urandom_range(0, 5));
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic fin, input bit quiet);
      int gap;
      gap = quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_source(input bit quiet);
      for (int i = 0; i < source_text.size(); i++) begin
         send_byte(source_text[i], i == source_text.size() - 1, quiet);
      end
      source_text.delete();
   endtask

   initial begin : stimulus
      int sent;
      sent = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Every token kind but keyword, bytes 0x00 and 0xFF, a number ended by a quote and a
      // string left open at the final byte.
      add_text("_q1 ");
      add_byte(8'h00);
      add_text("{}();.=");
      add_byte(8'hFF);
      add_byte(8'h09);
      add_text("12.5\"ok\"\"z");
      send_source(0);
      // A source of whitespace only, then a keyword closed by the final byte.
      add_text(" ");
      send_source(0);
      add_text("add");
      send_source(0);

      choke <= 1'b1;
      while (sent < RANDOM_BYTES) begin
         make_source();
         sent += source_text.size();
         send_source($urandom_range(0, 4) == 0);
      end
      req_tvalid <= 1'b0;
      @(posedge clock);

      while (tokens_outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("[source_text_tokenizer] OK");
      end else begin
         $display("[source_text_tokenizer] ERROR");
      end
      $finish;
   end

   // Result side back-pressure; one long hold-off once the random part starts,
   // so the block fills up and stops taking bytes.
   initial begin : receiver
      int gap;
      bit choked_done;
      choked_done = 0;
      while (reset) @(posedge clock);
      forever begin
         if (choke && !choked_done) begin
            choked_done = 1;
            rsp_tready <= 1'b0;
            repeat (CHOKE_CYCLES) @(posedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            if ($urandom_range(0, 15) == 0) begin
               repeat (60) @(posedge clock);
            end
         end
      end
   end

   initial begin : watchdog
      #10_000_000;
      $display("[source_text_tokenizer] ERROR");
      $finish;
   end

endmodule
